// ===== rtl/adsr_envelope_generator_unit_assert.svh =====
// assertion macros for the adsr envelope generator
// used by the top level; no other dependencies
`ifndef ADSR_ENVELOPE_GENERATOR_UNIT_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ADSR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ADSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/adsr_eg_pkg.sv =====
// shared types and constants for the adsr envelope generator
// no dependencies
package adsr_eg_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int LEVEL_W    = FRAC_BITS + 1;
  localparam int COEF_W     = 24;
  localparam int BASE_W     = 26;
  localparam int SUM_W      = BASE_W + 1;
  localparam int PROD_W     = LEVEL_W + COEF_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;
  localparam int PHASE_W    = 3;

  // unity level in fixed point
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK_COEF   = 3'd0,
    CFG_ATTACK_BASE   = 3'd1,
    CFG_DECAY_COEF    = 3'd2,
    CFG_DECAY_BASE    = 3'd3,
    CFG_RELEASE_COEF  = 3'd4,
    CFG_RELEASE_BASE  = 3'd5,
    CFG_SUSTAIN_LEVEL = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0]        attack_coef;
    logic signed [BASE_W-1:0] attack_base;
    logic [COEF_W-1:0]        decay_coef;
    logic signed [BASE_W-1:0] decay_base;
    logic [COEF_W-1:0]        release_coef;
    logic signed [BASE_W-1:0] release_base;
    logic [LEVEL_W-1:0]       sustain_level;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [LEVEL_W-1:0] level;
  } env_state_t;

endpackage

// ===== rtl/adsr_eg_in_if.sv =====
// input channel of the adsr envelope generator: one sample tick per item
// no dependencies
interface adsr_eg_in_if;
  logic valid;
  logic ready;
  logic gate_on;

  modport source (output valid, output gate_on, input ready);
  modport sink (input valid, input gate_on, output ready);
endinterface

// ===== rtl/adsr_eg_out_if.sv =====
// result channel of the adsr envelope generator: level and phase per item
// no dependencies
interface adsr_eg_out_if;
  logic        valid;
  logic        ready;
  logic [24:0] envelope;
  logic [2:0]  phase;

  modport source (output valid, output envelope, output phase, input ready);
  modport sink (input valid, input envelope, input phase, output ready);
endinterface

// ===== rtl/adsr_envelope_generator_unit.sv =====
// Exponential ADSR envelope generator. Each item on tick is one sample tick
// with the gate bit; each yields one result with the new envelope level
// (24 fractional bits, one is 2^24) and its phase (0 idle, 1 attack, 2 decay,
// 3 sustain, 4 release). Coefficients, bases and sustain level are written by
// software over the cfg port, indexes 0 to 6; software must do so only while no
// tick is in flight, which the block itself does not enforce. Throughput is one
// item per clock while result.ready holds: a tick is registered, then a single
// 25x24 multiply, add and clamp feeds the level and result registers in the
// same cycle. The result register lets the next tick enter while a result waits.
// depends on adsr_eg_pkg, adsr_eg_in_if, adsr_eg_out_if, adsr_eg_step
`include "adsr_envelope_generator_unit_assert.svh"

module adsr_envelope_generator_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [adsr_eg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adsr_eg_pkg::CFG_DATA_W-1:0] cfg_data,
  adsr_eg_in_if.sink                         tick,
  adsr_eg_out_if.source                      result
);

  adsr_eg_pkg::cfg_t                   cfg;
  adsr_eg_pkg::phase_t                 phase_reg;
  logic [adsr_eg_pkg::LEVEL_W-1:0]     level_reg;
  adsr_eg_pkg::env_state_t             step_next;

  logic                                s1_valid;
  logic                                s1_gate;
  logic                                out_valid;
  logic [adsr_eg_pkg::LEVEL_W-1:0]     out_envelope;
  adsr_eg_pkg::phase_t                 out_phase;
  logic                                out_free;
  logic                                s1_adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (adsr_eg_pkg::cfg_idx_t'(cfg_index))
        adsr_eg_pkg::CFG_ATTACK_COEF:
          cfg.attack_coef <= cfg_data[adsr_eg_pkg::COEF_W-1:0];
        adsr_eg_pkg::CFG_ATTACK_BASE:
          cfg.attack_base <= $signed(cfg_data[adsr_eg_pkg::BASE_W-1:0]);
        adsr_eg_pkg::CFG_DECAY_COEF:
          cfg.decay_coef <= cfg_data[adsr_eg_pkg::COEF_W-1:0];
        adsr_eg_pkg::CFG_DECAY_BASE:
          cfg.decay_base <= $signed(cfg_data[adsr_eg_pkg::BASE_W-1:0]);
        adsr_eg_pkg::CFG_RELEASE_COEF:
          cfg.release_coef <= cfg_data[adsr_eg_pkg::COEF_W-1:0];
        adsr_eg_pkg::CFG_RELEASE_BASE:
          cfg.release_base <= $signed(cfg_data[adsr_eg_pkg::BASE_W-1:0]);
        adsr_eg_pkg::CFG_SUSTAIN_LEVEL:
          cfg.sustain_level <= cfg_data[adsr_eg_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: input register moves on whenever the result register is free
  assign out_free   = !out_valid || result.ready;
  assign s1_adv     = s1_valid && out_free;
  assign tick.ready = !s1_valid || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_gate <= tick.gate_on;
    end
  end

  // envelope step
  adsr_eg_step u_step (
    .phase   (phase_reg),
    .level   (level_reg),
    .gate_on (s1_gate),
    .cfg     (cfg),
    .nxt     (step_next)
  );

  // envelope state, updated once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg <= adsr_eg_pkg::PH_IDLE;
      level_reg <= '0;
    end else if (s1_adv) begin
      phase_reg <= step_next.phase;
      level_reg <= step_next.level;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_envelope <= step_next.level;
      out_phase    <= step_next.phase;
    end
  end

  assign result.valid    = out_valid;
  assign result.envelope = out_envelope;
  assign result.phase    = out_phase;

  // checks
  `ADSR_ASSERT_NOW(a_result_matches_state, clk, rst, out_valid,
    (out_envelope == level_reg) && (out_phase == phase_reg),
    "pending result differs from envelope state")
  `ADSR_ASSERT_NOW(a_idle_level_zero, clk, rst, phase_reg == adsr_eg_pkg::PH_IDLE,
    level_reg == '0, "idle phase with nonzero level")
  `ADSR_ASSERT_NEXT(a_stage_advance, clk, rst, s1_adv, out_valid,
    "advanced item did not reach result register")

endmodule

// ===== rtl/adsr_eg_step.sv =====
// one envelope tick: segment multiply-add, clamping and phase transition
// depends on adsr_eg_pkg
module adsr_eg_step (
  input  adsr_eg_pkg::phase_t           phase,
  input  logic [adsr_eg_pkg::LEVEL_W-1:0] level,
  input  logic                          gate_on,
  input  adsr_eg_pkg::cfg_t             cfg,
  output adsr_eg_pkg::env_state_t       nxt
);

  localparam int LW = adsr_eg_pkg::LEVEL_W;
  localparam int SW = adsr_eg_pkg::SUM_W;
  localparam int PW = adsr_eg_pkg::PROD_W;

  logic [adsr_eg_pkg::COEF_W-1:0]        sel_coef;
  logic signed [adsr_eg_pkg::BASE_W-1:0] sel_base;
  logic [PW-1:0]                         prod;
  logic [LW-1:0]                         scaled;
  logic signed [SW-1:0]                  sum;
  logic signed [SW-1:0]                  one_s;
  logic signed [SW-1:0]                  sus_s;
  logic [LW-1:0]                         sus_clip;
  logic [LW-1:0]                         sat_val;
  logic                                  hit;
  logic [LW-1:0]                         step_level;
  adsr_eg_pkg::phase_t                   step_phase;

  // segment coefficients for the current phase
  always_comb begin
    case (phase)
      adsr_eg_pkg::PH_ATTACK: begin
        sel_coef = cfg.attack_coef;
        sel_base = cfg.attack_base;
      end
      adsr_eg_pkg::PH_DECAY: begin
        sel_coef = cfg.decay_coef;
        sel_base = cfg.decay_base;
      end
      default: begin
        sel_coef = cfg.release_coef;
        sel_base = cfg.release_base;
      end
    endcase
  end

  // base + floor(level * coef), level is never negative
  assign prod   = PW'(level) * PW'(sel_coef);
  assign scaled = prod[adsr_eg_pkg::FRAC_BITS +: LW];
  assign sum    = SW'(sel_base) + $signed({2'b00, scaled});

  // sustain above one acts as one
  assign sus_clip = (cfg.sustain_level > adsr_eg_pkg::LEVEL_ONE) ?
                    adsr_eg_pkg::LEVEL_ONE : cfg.sustain_level;
  assign one_s    = $signed({2'b00, adsr_eg_pkg::LEVEL_ONE});
  assign sus_s    = $signed({2'b00, sus_clip});

  // segment end test
  always_comb begin
    case (phase)
      adsr_eg_pkg::PH_ATTACK:  hit = (sum >= one_s);
      adsr_eg_pkg::PH_DECAY:   hit = (sum <= sus_s);
      adsr_eg_pkg::PH_RELEASE: hit = (sum <= SW'(0));
      default:                 hit = 1'b0;
    endcase
  end

  // saturate into 0 .. one
  always_comb begin
    if (sum < SW'(0)) begin
      sat_val = '0;
    end else if (sum > one_s) begin
      sat_val = adsr_eg_pkg::LEVEL_ONE;
    end else begin
      sat_val = sum[LW-1:0];
    end
  end

  // next level
  always_comb begin
    case (phase)
      adsr_eg_pkg::PH_ATTACK:  step_level = hit ? adsr_eg_pkg::LEVEL_ONE : sat_val;
      adsr_eg_pkg::PH_DECAY:   step_level = hit ? sus_clip : sat_val;
      adsr_eg_pkg::PH_RELEASE: step_level = hit ? '0 : sat_val;
      default:                 step_level = level;
    endcase
  end

  // next phase, gate wins over a segment end
  always_comb begin
    case (phase)
      adsr_eg_pkg::PH_ATTACK: begin
        if (!gate_on) step_phase = adsr_eg_pkg::PH_RELEASE;
        else          step_phase = hit ? adsr_eg_pkg::PH_DECAY : adsr_eg_pkg::PH_ATTACK;
      end
      adsr_eg_pkg::PH_DECAY: begin
        if (!gate_on) step_phase = adsr_eg_pkg::PH_RELEASE;
        else          step_phase = hit ? adsr_eg_pkg::PH_SUSTAIN : adsr_eg_pkg::PH_DECAY;
      end
      adsr_eg_pkg::PH_SUSTAIN: begin
        step_phase = gate_on ? adsr_eg_pkg::PH_SUSTAIN : adsr_eg_pkg::PH_RELEASE;
      end
      adsr_eg_pkg::PH_RELEASE: begin
        if (gate_on) step_phase = adsr_eg_pkg::PH_ATTACK;
        else         step_phase = hit ? adsr_eg_pkg::PH_IDLE : adsr_eg_pkg::PH_RELEASE;
      end
      default: begin
        step_phase = gate_on ? adsr_eg_pkg::PH_ATTACK : adsr_eg_pkg::PH_IDLE;
      end
    endcase
  end

  // packed next state
  assign nxt = '{phase: step_phase, level: step_level};

endmodule
